// ===== rtl/tsvm_pkg.sv =====
// tsvm_pkg: shared types and constants for the triggered sample voice mixer
// item and result payload structs, front-to-back command, control codes
// no dependencies; every rtl file refers to it by scoped names

package tsvm_pkg;

    // default sizing, handed to the top level parameters
    localparam int NUM_SOUNDS_DEF        = 8;
    localparam int NUM_VOICES_DEF        = 10;
    localparam int MAX_SOUND_SAMPLES_DEF = 4096;

    // fixed field widths
    localparam int SOUND_W  = 3;
    localparam int ADDR_W   = 12;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 13;
    localparam int HOLD_W   = 14;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 14;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_SOUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS = 1'd1;
    localparam logic [SOUND_W-1:0]     LOOP_SOUND_RESET = 3'd0;
    localparam logic [HOLD_W-1:0]      HOLD_TICKS_RESET = 14'd10000;

    // action codes of an input item
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_LENGTH = 2'd2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_SAMPLE,
        CMD_LENGTH
    } cmd_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_ALLOC,
        B_VOICE,
        B_DRAIN,
        B_MIX
    } back_state_t;

    typedef struct packed {
        logic [1:0]                 action;
        logic                       loop_button;
        logic                       bubble_button;
        logic                       ir_level;
        logic [SOUND_W-1:0]         random_sound;
        logic [SOUND_W-1:0]         sound_number;
        logic [ADDR_W-1:0]          sample_address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [LEN_W-1:0]           length_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] audio_out;
        logic                       led_on;
        logic                       loop_active;
        logic                       trigger_active;
        logic                       trigger_dropped;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t                  kind;
        logic                       loop_on;
        logic                       trig_on;
        logic                       loop_restart;
        logic                       fire;
        logic                       led;
        logic [SOUND_W-1:0]         rnd;
        logic [SOUND_W-1:0]         sound;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]           length;
    } cmd_t;

endpackage

// ===== rtl/triggered_sample_voice_mixer_unit.sv =====
// triggered_sample_voice_mixer_unit: top level of the sample voice mixer
// holds the configuration registers, joins front, command queue and back
// depends on tsvm_pkg, tsvm_front, tsvm_queue, tsvm_back
//
//   channel  | ports                           | carries
//   ---------+---------------------------------+-----------------------------
//   input    | s_valid s_ready s_data          | tick or load item
//   result   | m_valid m_ready m_data          | mixed sample and mode flags
//   config   | cfg_valid cfg_ready cfg_index   | loop_sound, hold_ticks
//            | cfg_data                        |
//
// a tick in the back end makes one sample store read for the loop voice and,
// with trigger mode on, then walks the pool one voice per cycle, all through
// the single store port. a result waiting on m_ready holds the back end.
// reset is synchronous, active low; sample contents are not cleared.
// the front keeps accepting into a four-entry command queue while the back
// works or the result register waits; cfg_ready is always high.

module triggered_sample_voice_mixer_unit #(
    parameter int NUM_SOUNDS        = tsvm_pkg::NUM_SOUNDS_DEF,
    parameter int NUM_VOICES        = tsvm_pkg::NUM_VOICES_DEF,
    parameter int MAX_SOUND_SAMPLES = tsvm_pkg::MAX_SOUND_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tsvm_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tsvm_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsvm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tsvm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [tsvm_pkg::SOUND_W-1:0] loop_sound_reg, loop_sound_next;
    logic [tsvm_pkg::HOLD_W-1:0]  hold_ticks_reg, hold_ticks_next;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    tsvm_pkg::cmd_t q_in;
    tsvm_pkg::cmd_t q_out;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_comb begin
        loop_sound_next = loop_sound_reg;
        hold_ticks_next = hold_ticks_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tsvm_pkg::CFG_LOOP_SOUND: loop_sound_next = cfg_data[tsvm_pkg::SOUND_W-1:0];
                tsvm_pkg::CFG_HOLD_TICKS: hold_ticks_next = cfg_data[tsvm_pkg::HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_sound_reg <= tsvm_pkg::LOOP_SOUND_RESET;
            hold_ticks_reg <= tsvm_pkg::HOLD_TICKS_RESET;
        end else begin
            loop_sound_reg <= loop_sound_next;
            hold_ticks_reg <= hold_ticks_next;
        end
    end

    tsvm_front #(
        .NUM_SOUNDS        (NUM_SOUNDS),
        .MAX_SOUND_SAMPLES (MAX_SOUND_SAMPLES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .hold_ticks (hold_ticks_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_in)
    );

    tsvm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    tsvm_back #(
        .NUM_SOUNDS        (NUM_SOUNDS),
        .NUM_VOICES        (NUM_VOICES),
        .MAX_SOUND_SAMPLES (MAX_SOUND_SAMPLES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .loop_sound (loop_sound_reg),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_cmd      (q_out),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/tsvm_front.sv =====
// tsvm_front: accepts input items, tracks buttons, modes and the ir hold count
// and turns each item into a command for the back end
// depends on tsvm_pkg

module tsvm_front #(
    parameter int NUM_SOUNDS        = tsvm_pkg::NUM_SOUNDS_DEF,
    parameter int MAX_SOUND_SAMPLES = tsvm_pkg::MAX_SOUND_SAMPLES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tsvm_pkg::in_item_t           s_data,
    input  logic [tsvm_pkg::HOLD_W-1:0]  hold_ticks,
    input  logic                         q_full,
    output logic                         q_push,
    output tsvm_pkg::cmd_t               q_cmd
);

    logic                        loop_mode_reg, loop_mode_next;
    logic                        trig_mode_reg, trig_mode_next;
    logic                        prev_lb_reg, prev_lb_next;
    logic                        prev_bb_reg, prev_bb_next;
    logic [tsvm_pkg::HOLD_W-1:0] hold_cnt_reg, hold_cnt_next;

    logic                        loop_fall;
    logic                        bubble_fall;
    logic                        loop_new;
    logic                        trig_new;
    logic [tsvm_pkg::HOLD_W:0]   cnt_inc;
    logic                        fire;
    logic [tsvm_pkg::HOLD_W-1:0] cnt_new;
    logic                        snd_ok;
    logic                        addr_ok;
    logic                        accept;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign accept  = q_push;

    // falling edges toggle the modes
    assign loop_fall   = !s_data.loop_button && prev_lb_reg;
    assign bubble_fall = !s_data.bubble_button && prev_bb_reg;
    assign loop_new    = loop_mode_reg ^ loop_fall;
    assign trig_new    = trig_mode_reg ^ bubble_fall;

    // ir hold counter, fires at or above the hold threshold
    assign cnt_inc = {1'b0, hold_cnt_reg} + 15'd1;
    always_comb begin
        fire    = 1'b0;
        cnt_new = hold_cnt_reg;
        if (trig_new) begin
            if (!s_data.ir_level) begin
                if (cnt_inc >= {1'b0, hold_ticks}) begin
                    fire    = 1'b1;
                    cnt_new = '0;
                end else begin
                    cnt_new = cnt_inc[tsvm_pkg::HOLD_W-1:0];
                end
            end else begin
                cnt_new = '0;
            end
        end
    end

    // range checks for load items
    assign snd_ok  = 32'(s_data.sound_number) < 32'(NUM_SOUNDS);
    assign addr_ok = 32'(s_data.sample_address) < 32'(MAX_SOUND_SAMPLES);

    // classify and build the command
    always_comb begin
        q_cmd.loop_on      = loop_mode_reg;
        q_cmd.trig_on      = trig_mode_reg;
        q_cmd.loop_restart = 1'b0;
        q_cmd.fire         = 1'b0;
        q_cmd.led          = !prev_lb_reg;
        q_cmd.rnd          = s_data.random_sound;
        q_cmd.sound        = s_data.sound_number;
        q_cmd.addr         = s_data.sample_address;
        q_cmd.sample       = s_data.sample_value;
        if (32'(s_data.length_value) > 32'(MAX_SOUND_SAMPLES)) begin
            q_cmd.length = tsvm_pkg::LEN_W'(MAX_SOUND_SAMPLES);
        end else begin
            q_cmd.length = s_data.length_value;
        end
        unique case (s_data.action)
            tsvm_pkg::ACT_TICK: begin
                q_cmd.kind         = tsvm_pkg::CMD_TICK;
                q_cmd.loop_on      = loop_new;
                q_cmd.trig_on      = trig_new;
                q_cmd.loop_restart = loop_fall && loop_new;
                q_cmd.fire         = fire;
                q_cmd.led          = !s_data.loop_button;
            end
            tsvm_pkg::ACT_SAMPLE: begin
                q_cmd.kind = (snd_ok && addr_ok) ? tsvm_pkg::CMD_SAMPLE : tsvm_pkg::CMD_NONE;
            end
            tsvm_pkg::ACT_LENGTH: begin
                q_cmd.kind = snd_ok ? tsvm_pkg::CMD_LENGTH : tsvm_pkg::CMD_NONE;
            end
            default: begin
                q_cmd.kind = tsvm_pkg::CMD_NONE;
            end
        endcase
    end

    // mode state advances on tick transfers only
    always_comb begin
        loop_mode_next = loop_mode_reg;
        trig_mode_next = trig_mode_reg;
        prev_lb_next   = prev_lb_reg;
        prev_bb_next   = prev_bb_reg;
        hold_cnt_next  = hold_cnt_reg;
        if (accept && s_data.action == tsvm_pkg::ACT_TICK) begin
            loop_mode_next = loop_new;
            trig_mode_next = trig_new;
            prev_lb_next   = s_data.loop_button;
            prev_bb_next   = s_data.bubble_button;
            hold_cnt_next  = cnt_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_mode_reg <= 1'b0;
            trig_mode_reg <= 1'b0;
            prev_lb_reg   <= 1'b0;
            prev_bb_reg   <= 1'b0;
            hold_cnt_reg  <= '0;
        end else begin
            loop_mode_reg <= loop_mode_next;
            trig_mode_reg <= trig_mode_next;
            prev_lb_reg   <= prev_lb_next;
            prev_bb_reg   <= prev_bb_next;
            hold_cnt_reg  <= hold_cnt_next;
        end
    end

endmodule

// ===== rtl/tsvm_queue.sv =====
// tsvm_queue: small command fifo between the front and back parts
// depends on tsvm_pkg for the command type and depth

module tsvm_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tsvm_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output tsvm_pkg::cmd_t pop_data,
    output logic           empty
);

    localparam int CntW = tsvm_pkg::QUEUE_PTR_W + 1;

    tsvm_pkg::cmd_t                   entry_reg [tsvm_pkg::QUEUE_DEPTH];
    logic [tsvm_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tsvm_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]                  count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full     = count_reg == CntW'(tsvm_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tsvm_back.sv =====
// tsvm_back: executes commands: sample store, length table, loop voice,
// voice pool walk, mixing and the result register
// depends on tsvm_pkg

module tsvm_back #(
    parameter int NUM_SOUNDS        = tsvm_pkg::NUM_SOUNDS_DEF,
    parameter int NUM_VOICES        = tsvm_pkg::NUM_VOICES_DEF,
    parameter int MAX_SOUND_SAMPLES = tsvm_pkg::MAX_SOUND_SAMPLES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tsvm_pkg::SOUND_W-1:0]  loop_sound,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  tsvm_pkg::cmd_t                q_cmd,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tsvm_pkg::out_item_t           m_data
);

    localparam int SndW       = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
    localparam int PosW       = $clog2(MAX_SOUND_SAMPLES);
    localparam int AddrW      = SndW + PosW;
    localparam int StoreDepth = NUM_SOUNDS * (2 ** PosW);
    localparam int VW         = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SumW       = tsvm_pkg::SAMPLE_W + $clog2(NUM_VOICES + 2);
    localparam int LenW       = tsvm_pkg::LEN_W;
    localparam int SW         = tsvm_pkg::SOUND_W;

    localparam logic [VW-1:0]          LastVoice = VW'(NUM_VOICES - 1);
    localparam logic signed [SumW-1:0] SatHi     = SumW'(32767);
    localparam logic signed [SumW-1:0] SatLo     = SumW'(-32768);

    tsvm_pkg::back_state_t state_reg, state_next;
    tsvm_pkg::cmd_t        cmd_reg, cmd_next;

    logic [LenW-1:0]   len_reg [NUM_SOUNDS];
    logic [LenW-1:0]   len_next [NUM_SOUNDS];
    logic [LenW-1:0]   loop_pos_reg, loop_pos_next;
    logic              busy_reg [NUM_VOICES];
    logic              busy_next [NUM_VOICES];
    logic [SW-1:0]     vsnd_reg [NUM_VOICES];
    logic [SW-1:0]     vsnd_next [NUM_VOICES];
    logic [LenW-1:0]   vpos_reg [NUM_VOICES];
    logic [LenW-1:0]   vpos_next [NUM_VOICES];
    logic [VW-1:0]     vidx_reg, vidx_next;

    logic signed [SumW-1:0] sum_reg, sum_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   dropped_reg, dropped_next;
    logic                   m_valid_reg, m_valid_next;
    tsvm_pkg::out_item_t    m_data_reg, m_data_next;

    // sample store port
    logic [tsvm_pkg::SAMPLE_W-1:0] store [StoreDepth];
    logic [tsvm_pkg::SAMPLE_W-1:0] rdata_reg;
    logic                          mem_we;
    logic                          mem_re;
    logic [AddrW-1:0]              mem_addr;

    logic [SW-1:0]          len_snd;
    logic [LenW-1:0]        len_sel;
    logic [LenW-1:0]        pos0;
    logic [LenW:0]          pos_inc;
    logic                   any_free;
    logic [VW-1:0]          free_idx;
    logic signed [SumW-1:0] half;
    logic signed [SumW-1:0] mixed;
    logic                   out_free;

    function automatic logic [AddrW-1:0] store_addr(input logic [SW-1:0] snd,
                                                     input logic [LenW-1:0] pos);
        logic [31:0] s32;
        logic [31:0] p32;
        s32 = 32'(snd);
        p32 = 32'(pos);
        return {s32[SndW-1:0], p32[PosW-1:0]};
    endfunction

    function automatic logic [SndW-1:0] snd_idx(input logic [SW-1:0] snd);
        logic [31:0] s32;
        s32 = 32'(snd);
        return s32[SndW-1:0];
    endfunction

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // single length lookup: loop sound in exec, current voice otherwise
    assign len_snd = (state_reg == tsvm_pkg::B_EXEC) ? loop_sound : vsnd_reg[vidx_reg];
    assign len_sel = (32'(len_snd) < 32'(NUM_SOUNDS)) ? len_reg[snd_idx(len_snd)] : '0;

    // lowest free voice
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                any_free = 1'b1;
                free_idx = VW'(i);
            end
        end
    end

    // halve when both modes are on (floor), then saturate
    assign half = (cmd_reg.loop_on && cmd_reg.trig_on) ? (sum_reg >>> 1) : sum_reg;
    always_comb begin
        if (half > SatHi) begin
            mixed = SatHi;
        end else if (half < SatLo) begin
            mixed = SatLo;
        end else begin
            mixed = half;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tsvm_pkg::B_IDLE: begin
                if (!q_empty) begin
                    state_next = tsvm_pkg::B_EXEC;
                end
            end
            tsvm_pkg::B_EXEC: begin
                state_next = (cmd_reg.kind == tsvm_pkg::CMD_TICK) ? tsvm_pkg::B_ALLOC
                                                                  : tsvm_pkg::B_MIX;
            end
            tsvm_pkg::B_ALLOC: begin
                state_next = cmd_reg.trig_on ? tsvm_pkg::B_VOICE : tsvm_pkg::B_DRAIN;
            end
            tsvm_pkg::B_VOICE: begin
                if (vidx_reg == LastVoice) begin
                    state_next = tsvm_pkg::B_DRAIN;
                end
            end
            tsvm_pkg::B_DRAIN: begin
                state_next = tsvm_pkg::B_MIX;
            end
            tsvm_pkg::B_MIX: begin
                if (out_free) begin
                    state_next = tsvm_pkg::B_IDLE;
                end
            end
            default: begin
                state_next = tsvm_pkg::B_IDLE;
            end
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = '0;
        pos0          = '0;
        pos_inc       = '0;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        loop_pos_next = loop_pos_reg;
        busy_next     = busy_reg;
        vsnd_next     = vsnd_reg;
        vpos_next     = vpos_reg;
        vidx_next     = vidx_reg;
        dropped_next  = dropped_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        // registered read data is added to the sum in the cycle after the read
        sum_next      = pend_reg ? sum_reg + SumW'(signed'(rdata_reg)) : sum_reg;

        unique case (state_reg)
            tsvm_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop        = 1'b1;
                    cmd_next     = q_cmd;
                    sum_next     = '0;
                    dropped_next = 1'b0;
                end
            end
            tsvm_pkg::B_EXEC: begin
                unique case (cmd_reg.kind)
                    tsvm_pkg::CMD_SAMPLE: begin
                        mem_we   = 1'b1;
                        mem_addr = store_addr(cmd_reg.sound, {1'b0, cmd_reg.addr});
                    end
                    tsvm_pkg::CMD_LENGTH: begin
                        len_next[snd_idx(cmd_reg.sound)] = cmd_reg.length;
                    end
                    tsvm_pkg::CMD_TICK: begin
                        // loop voice: read current position, advance and wrap
                        if (cmd_reg.loop_on) begin
                            pos0    = cmd_reg.loop_restart ? '0 : loop_pos_reg;
                            pos_inc = {1'b0, pos0} + 1'b1;
                            if (pos0 < len_sel) begin
                                mem_re   = 1'b1;
                                mem_addr = store_addr(loop_sound, pos0);
                            end
                            loop_pos_next = (pos_inc >= {1'b0, len_sel}) ? '0
                                                                         : pos_inc[LenW-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tsvm_pkg::B_ALLOC: begin
                vidx_next = '0;
                if (cmd_reg.trig_on && cmd_reg.fire) begin
                    if (any_free) begin
                        busy_next[free_idx] = 1'b1;
                        vsnd_next[free_idx] = cmd_reg.rnd;
                        vpos_next[free_idx] = '0;
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
            tsvm_pkg::B_VOICE: begin
                // one voice per cycle: advance, retire at the end, else read
                if (busy_reg[vidx_reg]) begin
                    pos_inc = {1'b0, vpos_reg[vidx_reg]} + 1'b1;
                    if (pos_inc >= {1'b0, len_sel}) begin
                        busy_next[vidx_reg] = 1'b0;
                        vsnd_next[vidx_reg] = '0;
                        vpos_next[vidx_reg] = '0;
                    end else begin
                        vpos_next[vidx_reg] = pos_inc[LenW-1:0];
                        mem_re              = 1'b1;
                        mem_addr = store_addr(vsnd_reg[vidx_reg], pos_inc[LenW-1:0]);
                    end
                end
                if (vidx_reg != LastVoice) begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            tsvm_pkg::B_DRAIN: begin
            end
            tsvm_pkg::B_MIX: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.audio_out       = mixed[tsvm_pkg::SAMPLE_W-1:0];
                    m_data_next.led_on          = cmd_reg.led;
                    m_data_next.loop_active     = cmd_reg.loop_on;
                    m_data_next.trigger_active  = cmd_reg.trig_on;
                    m_data_next.trigger_dropped = dropped_reg;
                end
            end
            default: begin
            end
        endcase
        pend_next = mem_re;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tsvm_pkg::B_IDLE;
            len_reg      <= '{default: '0};
            loop_pos_reg <= '0;
            busy_reg     <= '{default: 1'b0};
            vidx_reg     <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            loop_pos_reg <= loop_pos_next;
            busy_reg     <= busy_next;
            vidx_reg     <= vidx_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        vsnd_reg    <= vsnd_next;
        vpos_reg    <= vpos_next;
        sum_reg     <= sum_next;
        dropped_reg <= dropped_next;
        m_data_reg  <= m_data_next;
    end

    // sample store, one port, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store[mem_addr] <= cmd_reg.sample;
        end
        if (mem_re) begin
            rdata_reg <= store[mem_addr];
        end
    end

endmodule

// ===== tb/tsvm_mixer_checker.sv =====
// tsvm_mixer_checker: watches the item, result and register channels of the mixer
// mirrors the mixer state to predict each result and compares it field by field
// depends on tsvm_pkg for the payload structs and register codes

module tsvm_mixer_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  tsvm_pkg::in_item_t                s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  tsvm_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [tsvm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tsvm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import tsvm_pkg::*;

    localparam int SOUNDS      = NUM_SOUNDS_DEF;
    localparam int VOICES      = NUM_VOICES_DEF;
    localparam int SOUND_DEPTH = MAX_SOUND_SAMPLES_DEF;
    localparam int PRINT_LIMIT = 50;

    // mirrored registers and mixer state
    logic [SOUND_W-1:0]  loop_sel;
    logic [HOLD_W-1:0]   hold_limit;
    bit                  loop_on;
    bit                  trig_on;
    bit                  prev_loop_btn;
    bit                  prev_bubble_btn;
    int unsigned         loop_pos;
    int unsigned         ir_count;
    bit                  voice_on [VOICES];
    logic [SOUND_W-1:0]  voice_snd [VOICES];
    int unsigned         voice_pos [VOICES];
    logic [SAMPLE_W-1:0] wave_mem [SOUNDS*SOUND_DEPTH];
    int unsigned         wave_len [SOUNDS];

    // predicted results, oldest first
    out_item_t mix_queue [$];
    int        result_idx;

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch in %s on result %0d: got %0d, want %0d",
                     field, result_idx, got, want);
        end
    endtask

    function automatic int unsigned sound_len(input logic [SOUND_W-1:0] snd);
        return (int'(snd) < SOUNDS) ? wave_len[snd] : 0;
    endfunction

    function automatic int wave_at(input logic [SOUND_W-1:0] snd, input int unsigned pos);
        return int'($signed(wave_mem[int'(snd) * SOUND_DEPTH + int'(pos)]));
    endfunction

    // advance the mirrored state by one item and return its result
    function automatic out_item_t mix_item(input in_item_t it);
        out_item_t   r;
        int          acc;
        int          slot;
        bit          fire;
        int unsigned len;
        r = '0;
        acc = 0;
        fire = 1'b0;
        slot = -1;

        // load items and the spare action code
        if (it.action != ACT_TICK) begin
            if (it.action == ACT_SAMPLE && int'(it.sound_number) < SOUNDS &&
                int'(it.sample_address) < SOUND_DEPTH) begin
                wave_mem[int'(it.sound_number) * SOUND_DEPTH + int'(it.sample_address)] =
                    it.sample_value;
            end else if (it.action == ACT_LENGTH && int'(it.sound_number) < SOUNDS) begin
                wave_len[it.sound_number] = (int'(it.length_value) > SOUND_DEPTH) ?
                                            SOUND_DEPTH : it.length_value;
            end
            r.led_on = ~prev_loop_btn;
            r.loop_active = loop_on;
            r.trigger_active = trig_on;
            return r;
        end

        // falling button edges toggle the modes
        if (!it.loop_button && prev_loop_btn) begin
            loop_on = !loop_on;
            if (loop_on) loop_pos = 0;
        end
        if (!it.bubble_button && prev_bubble_btn) trig_on = !trig_on;
        prev_loop_btn = it.loop_button;
        prev_bubble_btn = it.bubble_button;

        // loop voice, stale positions add nothing and wrap
        if (loop_on) begin
            len = sound_len(loop_sel);
            if (loop_pos < len) acc += wave_at(loop_sel, loop_pos);
            loop_pos++;
            if (loop_pos >= len) loop_pos = 0;
        end

        if (trig_on) begin
            // infrared hold counter
            if (!it.ir_level) begin
                ir_count++;
                if (ir_count >= hold_limit) begin
                    fire = 1'b1;
                    ir_count = 0;
                end
            end else begin
                ir_count = 0;
            end
            // lowest free voice takes the new sound
            if (fire) begin
                for (int v = 0; v < VOICES; v++) begin
                    if (!voice_on[v] && slot < 0) slot = v;
                end
                if (slot < 0) begin
                    r.trigger_dropped = 1'b1;
                end else begin
                    voice_on[slot] = 1'b1;
                    voice_snd[slot] = it.random_sound;
                    voice_pos[slot] = 0;
                end
            end
            // busy voices step first, then play or retire
            for (int v = 0; v < VOICES; v++) begin
                if (voice_on[v]) begin
                    voice_pos[v]++;
                    if (voice_pos[v] >= sound_len(voice_snd[v])) begin
                        voice_on[v] = 1'b0;
                        voice_snd[v] = '0;
                        voice_pos[v] = 0;
                    end else begin
                        acc += wave_at(voice_snd[v], voice_pos[v]);
                    end
                end
            end
        end

        // halve toward minus infinity when both modes run, then clamp
        if (loop_on && trig_on) acc = acc >>> 1;
        if (acc > 32767) acc = 32767;
        else if (acc < -32768) acc = -32768;

        r.audio_out = acc[SAMPLE_W-1:0];
        r.led_on = ~it.loop_button;
        r.loop_active = loop_on;
        r.trigger_active = trig_on;
        return r;
    endfunction

    // register writes, result compare, then prediction of the new item
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            loop_sel = LOOP_SOUND_RESET;
            hold_limit = HOLD_TICKS_RESET;
            loop_on = 1'b0;
            trig_on = 1'b0;
            prev_loop_btn = 1'b0;
            prev_bubble_btn = 1'b0;
            loop_pos = 0;
            ir_count = 0;
            for (int v = 0; v < VOICES; v++) begin
                voice_on[v] = 1'b0;
                voice_snd[v] = '0;
                voice_pos[v] = 0;
            end
            for (int s = 0; s < SOUNDS; s++) wave_len[s] = 0;
            mix_queue.delete();
            result_idx = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOOP_SOUND: loop_sel = cfg_data[SOUND_W-1:0];
                    CFG_HOLD_TICKS: hold_limit = cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mix_queue.size() == 0) begin
                    report_mismatch("result with nothing pending", int'(m_data.audio_out), 0);
                end else begin
                    want = mix_queue.pop_front();
                    if (m_data.audio_out !== want.audio_out)
                        report_mismatch("audio_out", int'(m_data.audio_out),
                                        int'(want.audio_out));
                    if (m_data.led_on !== want.led_on)
                        report_mismatch("led_on", int'(m_data.led_on), int'(want.led_on));
                    if (m_data.loop_active !== want.loop_active)
                        report_mismatch("loop_active", int'(m_data.loop_active),
                                        int'(want.loop_active));
                    if (m_data.trigger_active !== want.trigger_active)
                        report_mismatch("trigger_active", int'(m_data.trigger_active),
                                        int'(want.trigger_active));
                    if (m_data.trigger_dropped !== want.trigger_dropped)
                        report_mismatch("trigger_dropped", int'(m_data.trigger_dropped),
                                        int'(want.trigger_dropped));
                end
                result_idx++;
            end
            if (s_valid && s_ready) mix_queue.push_back(mix_item(s_data));
        end
        outstanding <= mix_queue.size();
    end

endmodule

// ===== tb/tb_triggered_sample_voice_mixer_unit.sv =====
// tb_triggered_sample_voice_mixer_unit: clock, reset and stimulus for the mixer
// drives directed and random items through several idling phases, gives the verdict
// depends on tsvm_pkg, triggered_sample_voice_mixer_unit and tsvm_mixer_checker

module tb_triggered_sample_voice_mixer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tsvm_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 130;
    localparam int SOUNDS         = NUM_SOUNDS_DEF;
    localparam int SOUND_DEPTH    = MAX_SOUND_SAMPLES_DEF;
    // action code with no meaning, the block treats it as an empty load
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     mismatches;
    int                     outstanding;

    // idling controls and the long receiver hold-off
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_asked = 0;
    int holdoff_served = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    // button levels and a guess of the modes, used only to steer presses
    bit lb_lvl;
    bit bb_lvl;
    bit loop_guess;
    bit trig_guess;

    // written sample entries; lengths never go past the written prefix
    bit wave_written [SOUNDS*SOUND_DEPTH];
    int wave_prefix [SOUNDS];

    logic [SAMPLE_W-1:0] corner_vals [6] = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                                             16'h0001, 16'hffff};

    triggered_sample_voice_mixer_unit dut (.*);

    tsvm_mixer_checker mix_chk (.*);

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // receiver ready, with random stalls and the long hold-off
    always @(posedge aclk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else if (holdoff_served != holdoff_asked) begin
            holdoff_served = holdoff_asked;
            holdoff_left = HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_item_t tick_item(input bit lb, input bit bb, input bit ir,
                                           input logic [SOUND_W-1:0] rnd);
        in_item_t    it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.action = ACT_TICK;
        it.loop_button = lb;
        it.bubble_button = bb;
        it.ir_level = ir;
        it.random_sound = rnd;
        return it;
    endfunction

    function automatic in_item_t load_item(input logic [1:0] act, input int snd,
                                           input int addr, input logic [SAMPLE_W-1:0] val,
                                           input int len);
        in_item_t    it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.action = act;
        it.sound_number = SOUND_W'(snd);
        it.sample_address = ADDR_W'(addr);
        it.sample_value = val;
        it.length_value = LEN_W'(len);
        return it;
    endfunction

    function automatic void note_written(input int snd, input int addr);
        wave_written[snd * SOUND_DEPTH + addr] = 1'b1;
        while (wave_prefix[snd] < SOUND_DEPTH &&
               wave_written[snd * SOUND_DEPTH + wave_prefix[snd]])
            wave_prefix[snd]++;
    endfunction

    // one item transfer, with a random gap before it; valid stays up afterward
    task automatic push_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // both registers, back to back
    task automatic program_mixer(input logic [SOUND_W-1:0] snd,
                                 input logic [HOLD_W-1:0] hold);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOOP_SOUND;
        cfg_data <= CFG_DATA_W'(snd);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_data <= CFG_DATA_W'(hold);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // sender pauses until every predicted result has come back
    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly ticks steering both modes on, plus sample and length loads and spare action items
    task automatic send_random_item();
        int                  pick;
        int                  snd;
        int                  addr;
        int                  len;
        logic [SAMPLE_W-1:0] val;
        logic [SOUND_W-1:0]  rnd;
        pick = $urandom_range(99);
        if (pick < 30) begin
            if ($urandom_range(99) < 85) begin
                snd = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(7, 4);
                addr = (wave_prefix[snd] < SOUND_DEPTH) ? wave_prefix[snd]
                                                        : $urandom_range(SOUND_DEPTH - 1);
            end else begin
                snd = $urandom_range(SOUNDS - 1);
                addr = $urandom_range(SOUND_DEPTH - 1);
            end
            case ($urandom_range(9))
                0: val = 16'h7fff;
                1: val = 16'h8000;
                default: val = SAMPLE_W'($urandom);
            endcase
            note_written(snd, addr);
            push_item(load_item(ACT_SAMPLE, snd, addr, val, 0));
        end else if (pick < 36) begin
            snd = $urandom_range(SOUNDS - 1);
            // oversized length saturates, replaced before any tick can play it
            if ($urandom_range(99) < 20)
                push_item(load_item(ACT_LENGTH, snd, 0, 0, $urandom_range(8191, SOUND_DEPTH + 1)));
            len = $urandom_range(wave_prefix[snd], (wave_prefix[snd] * 3) / 4);
            push_item(load_item(ACT_LENGTH, snd, 0, 0, len));
        end else if (pick < 38) begin
            push_item(load_item(ACT_SPARE, $urandom_range(7), $urandom_range(4095),
                                SAMPLE_W'($urandom), $urandom_range(8191)));
        end else begin
            if (lb_lvl) begin
                if ($urandom_range(1)) begin
                    lb_lvl = 1'b0;
                    loop_guess = !loop_guess;
                end
            end else if ($urandom_range(99) < (loop_guess ? 3 : 25)) begin
                lb_lvl = 1'b1;
            end
            if (bb_lvl) begin
                if ($urandom_range(1)) begin
                    bb_lvl = 1'b0;
                    trig_guess = !trig_guess;
                end
            end else if ($urandom_range(99) < (trig_guess ? 3 : 25)) begin
                bb_lvl = 1'b1;
            end
            rnd = ($urandom_range(99) < 75) ? SOUND_W'($urandom_range(3))
                                            : SOUND_W'($urandom_range(7));
            push_item(tick_item(lb_lvl, bb_lvl, $urandom_range(99) < 20, rnd));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: corner samples, oversized length, spare action, both modes,
        // zero hold count firing every low tick
        program_mixer(3'd0, 14'd0);
        for (int k = 0; k < 6; k++) begin
            note_written(0, k);
            push_item(load_item(ACT_SAMPLE, 0, k, corner_vals[k], 0));
        end
        push_item(load_item(ACT_LENGTH, 0, 0, 0, 6));
        push_item(load_item(ACT_LENGTH, 1, 0, 0, 8191));
        push_item(load_item(ACT_LENGTH, 1, 0, 0, 0));
        push_item(load_item(ACT_SPARE, 2, 4095, 16'h5555, 4096));
        push_item(tick_item(1'b1, 1'b0, 1'b1, 3'd0));
        for (int k = 0; k < 4; k++) push_item(tick_item(1'b0, 1'b0, 1'b1, 3'd0));
        push_item(tick_item(1'b0, 1'b1, 1'b1, 3'd0));
        for (int k = 0; k < 7; k++) push_item(tick_item(1'b0, 1'b0, 1'b0, 3'd0));
        lb_lvl = 1'b0;
        bb_lvl = 1'b0;
        loop_guess = 1'b1;
        trig_guess = 1'b1;

        // random phases with different settings and idling
        for (int phase = 0; phase < 4; phase++) begin
            wait_drain();
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                    program_mixer(3'd7, 14'd2);
                end
                1: begin
                    send_idle_pct = 65;
                    recv_stall_pct <= 0;
                    program_mixer(3'd3, 14'd1);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 65;
                    program_mixer(3'd5, 14'd16383);
                end
                default: begin
                    send_idle_pct = 10;
                    recv_stall_pct <= 10;
                    program_mixer(SOUND_W'($urandom_range(7)), 14'd0);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver holds off while items keep coming, filling the block
                if (phase == 0 && n == 40) holdoff_asked <= holdoff_asked + 1;
                send_random_item();
            end
        end

        wait_drain();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
